>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the page store modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/ffps_pkg.sv
// ----------------------------------------------------------------------------
// First-fit page store package
// Command, status and state codes used by the front and back modules.
// ----------------------------------------------------------------------------
package ffps_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_DROPPED   = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_MISSING   = 3'd4;
	localparam logic [2:0] ST_ROW       = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	localparam logic [15:0] HEADER_BYTES = 16'd16;
	localparam logic [15:0] PAGE_CAP_RESET = 16'd4096;
	localparam int RESULT_LIMIT = 16;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] record_size;
		logic [31:0] key;
	} cmd_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_INS_SCAN,
		BK_SRCH_REQ,
		BK_SRCH_CMP,
		BK_STAT,
		BK_EMIT
	} bk_state_t;

endpackage

>>> hdl/ffps_front.sv
// ----------------------------------------------------------------------------
// First-fit page store front end
// Accepts items, drops unused commands and queues the rest for the back end.
// ----------------------------------------------------------------------------
module ffps_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [15:0]          record_size,
	input  logic signed [31:0]   key,
	output logic                 q_valid,
	input  logic                 q_ready,
	output ffps_pkg::cmd_item_t  q_item
);

	ffps_pkg::cmd_item_t item_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic       pop;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready && (command != ffps_pkg::CMD_NONE);
	assign pop      = q_valid && q_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = item_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= '{command: command, record_size: record_size,
				key: key};
		end
	end

endmodule

>>> hdl/ffps_back.sv
// ----------------------------------------------------------------------------
// First-fit page store back end
// Walks pages for inserts and status, and reads stored keys for searches.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffps_back #(
	parameter int MAX_PAGES     = 16,
	parameter int MAX_SLOTS     = 64,
	parameter int SLOT_OVERHEAD = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          page_cap,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  ffps_pkg::cmd_item_t  q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [3:0]           page_id,
	output logic [5:0]           slot_id,
	output logic [4:0]           page_count,
	output logic [6:0]           record_count,
	output logic                 last,
	output logic                 busy
);

	localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int RCW = $clog2(MAX_SLOTS + 1);
	localparam int AW  = PW + SW;
	localparam logic [PCW-1:0] PAGES_MAX = PCW'(MAX_PAGES);
	localparam logic [RCW-1:0] SLOTS_MAX = RCW'(MAX_SLOTS);

	ffps_pkg::bk_state_t state_q, state_d;

	logic [16:0]    bytes_used_q [MAX_PAGES];
	logic [RCW-1:0] recs_q [MAX_PAGES];
	logic [PCW-1:0] pages_open_q;
	logic [31:0]    key_mem [MAX_PAGES*MAX_SLOTS];
	logic [31:0]    rd_key_q;

	ffps_pkg::cmd_item_t cur_q;
	logic [PW-1:0]  pg_q;
	logic [RCW-1:0] sl_q;
	logic [PCW-1:0] cnt_q;
	logic           retry_q;

	logic           res_valid_q;
	logic [2:0]     res_status_q;
	logic [PW-1:0]  res_page_q;
	logic [SW-1:0]  res_slot_q;
	logic [PCW-1:0] res_pc_q;
	logic [RCW-1:0] res_rc_q;
	logic           res_last_q;

	logic [17:0] need;
	logic        fits;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic        is_last_page;
	logic        last_row;
	logic        slot_end;
	logic        load_res;

	assign need = 18'(bytes_used_q[pg_q]) + 18'(cur_q.record_size)
		+ 18'(SLOT_OVERHEAD);
	assign fits = (bytes_used_q[pg_q] < {1'b0, page_cap})
		&& (recs_q[pg_q] < SLOTS_MAX) && (need <= 18'(page_cap));
	assign wr_addr = {pg_q, recs_q[pg_q][SW-1:0]};
	assign rd_addr = {pg_q, sl_q[SW-1:0]};
	assign is_last_page = ((PCW+1)'(pg_q) + (PCW+1)'(1)) >= (PCW+1)'(pages_open_q);
	assign last_row = ((PCW+1)'(pg_q) + (PCW+1)'(1)) >= (PCW+1)'(cnt_q);
	assign slot_end = (sl_q >= recs_q[pg_q]);
	assign q_ready = (state_q == ffps_pkg::BK_IDLE) && !res_valid_q;
	assign busy = (state_q != ffps_pkg::BK_IDLE) || res_valid_q;
	assign load_res = ((state_q == ffps_pkg::BK_STAT) || (state_q == ffps_pkg::BK_EMIT))
		&& (!res_valid_q || out_ready);

	assign out_valid    = res_valid_q;
	assign status       = res_status_q;
	assign page_id      = 4'(res_page_q);
	assign slot_id      = 6'(res_slot_q);
	assign page_count   = 5'(res_pc_q);
	assign record_count = 7'(res_rc_q);
	assign last         = res_last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffps_pkg::BK_IDLE: begin
				if (q_valid && q_ready) begin
					unique case (q_item.command)
						ffps_pkg::CMD_INSERT: state_d = ffps_pkg::BK_INS_SCAN;
						ffps_pkg::CMD_SEARCH: state_d = ffps_pkg::BK_SRCH_REQ;
						default:              state_d = ffps_pkg::BK_STAT;
					endcase
				end
			end
			ffps_pkg::BK_INS_SCAN: begin
				if (fits || retry_q || (is_last_page && pages_open_q >= PAGES_MAX))
					state_d = ffps_pkg::BK_EMIT;
			end
			ffps_pkg::BK_SRCH_REQ: begin
				if (slot_end && is_last_page) state_d = ffps_pkg::BK_EMIT;
				else if (!slot_end)           state_d = ffps_pkg::BK_SRCH_CMP;
			end
			ffps_pkg::BK_SRCH_CMP: begin
				if (rd_key_q == cur_q.key) state_d = ffps_pkg::BK_EMIT;
				else                       state_d = ffps_pkg::BK_SRCH_REQ;
			end
			ffps_pkg::BK_STAT: begin
				if (load_res && last_row) state_d = ffps_pkg::BK_IDLE;
			end
			ffps_pkg::BK_EMIT: begin
				if (load_res) state_d = ffps_pkg::BK_IDLE;
			end
			default: state_d = ffps_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffps_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ffps_pkg::BK_SRCH_REQ) rd_key_q <= key_mem[rd_addr];
		if (state_q == ffps_pkg::BK_INS_SCAN && fits) key_mem[wr_addr] <= cur_q.key;
	end

	// Page table, walk counters and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++) begin
				bytes_used_q[i] <= {1'b0, ffps_pkg::HEADER_BYTES};
				recs_q[i] <= '0;
			end
			pages_open_q <= PCW'(1);
			pg_q         <= '0;
			sl_q         <= '0;
			cnt_q        <= '0;
			retry_q      <= 1'b0;
			cur_q        <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= '0;
			res_page_q   <= '0;
			res_slot_q   <= '0;
			res_pc_q     <= '0;
			res_rc_q     <= '0;
			res_last_q   <= 1'b0;
		end else begin
			if (load_res) res_valid_q <= 1'b1;
			else if (res_valid_q && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ffps_pkg::BK_IDLE: begin
					pg_q <= '0;
					sl_q <= '0;
					retry_q <= 1'b0;
					cur_q <= q_item;
					cnt_q <= (pages_open_q > PCW'(ffps_pkg::RESULT_LIMIT))
						? PCW'(ffps_pkg::RESULT_LIMIT) : pages_open_q;
				end
				ffps_pkg::BK_INS_SCAN: begin
					res_last_q <= 1'b1;
					if (fits) begin
						recs_q[pg_q]       <= recs_q[pg_q] + RCW'(1);
						bytes_used_q[pg_q] <= need[16:0];
						res_status_q <= ffps_pkg::ST_STORED;
						res_page_q   <= pg_q;
						res_slot_q   <= recs_q[pg_q][SW-1:0];
						res_pc_q     <= pages_open_q;
						res_rc_q     <= recs_q[pg_q] + RCW'(1);
					end else if (retry_q) begin
						res_status_q <= ffps_pkg::ST_DROPPED;
						res_page_q   <= pg_q;
						res_slot_q   <= '0;
						res_pc_q     <= pages_open_q;
						res_rc_q     <= '0;
					end else if (!is_last_page) begin
						pg_q <= pg_q + PW'(1);
					end else if (pages_open_q >= PAGES_MAX) begin
						res_status_q <= ffps_pkg::ST_EXHAUSTED;
						res_page_q   <= '0;
						res_slot_q   <= '0;
						res_pc_q     <= pages_open_q;
						res_rc_q     <= '0;
					end else begin
						// Open a new page and retry there once.
						pages_open_q <= pages_open_q + PCW'(1);
						pg_q <= PW'(pages_open_q);
						bytes_used_q[PW'(pages_open_q)] <= {1'b0, ffps_pkg::HEADER_BYTES};
						recs_q[PW'(pages_open_q)] <= '0;
						retry_q <= 1'b1;
					end
				end
				ffps_pkg::BK_SRCH_REQ: begin
					res_status_q <= ffps_pkg::ST_MISSING;
					res_page_q   <= '0;
					res_slot_q   <= '0;
					res_pc_q     <= pages_open_q;
					res_rc_q     <= '0;
					res_last_q   <= 1'b1;
					if (slot_end && !is_last_page) begin
						pg_q <= pg_q + PW'(1);
						sl_q <= '0;
					end
				end
				ffps_pkg::BK_SRCH_CMP: begin
					if (rd_key_q == cur_q.key) begin
						res_status_q <= ffps_pkg::ST_FOUND;
						res_page_q   <= pg_q;
						res_slot_q   <= sl_q[SW-1:0];
						res_rc_q     <= recs_q[pg_q];
					end else begin
						sl_q <= sl_q + RCW'(1);
					end
				end
				ffps_pkg::BK_STAT: begin
					if (load_res) begin
						res_slot_q <= '0;
						if (pages_open_q == PCW'(1) && recs_q[0] == '0) begin
							res_status_q <= ffps_pkg::ST_EMPTY;
							res_page_q   <= '0;
							res_pc_q     <= '0;
							res_rc_q     <= '0;
							res_last_q   <= 1'b1;
						end else begin
							res_status_q <= ffps_pkg::ST_ROW;
							res_page_q   <= pg_q;
							res_pc_q     <= pages_open_q;
							res_rc_q     <= recs_q[pg_q];
							res_last_q   <= last_row;
							pg_q <= pg_q + PW'(1);
						end
					end
				end
				ffps_pkg::BK_EMIT: ;
				default: ;
			endcase
		end
	end

	`ASSERT_IMPL(a_pages_bounded, clk, arst_n, 1'b1, pages_open_q <= PAGES_MAX)
	`ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status))
	`ASSERT_IMPL(a_idle_ready, clk, arst_n, q_ready,
		state_q == ffps_pkg::BK_IDLE)

endmodule

>>> hdl/first_fit_page_record_store.sv
// ----------------------------------------------------------------------------
// First-fit page record store
// Heap-file page store with first-fit insert, key search and status report.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready with command, record_size and key. Results
// leave on out_valid/out_ready with status, page_id, slot_id, page_count,
// record_count and last; last marks the final result of an item.
// The page capacity register is written on cfg_valid/cfg_ready; the user must
// write it only while idle, as the block does not enforce it. A two-entry
// queue separates the front end from the back end, so items are taken while
// earlier ones are still in work. An insert scans the pages in order and
// opens a new page for one retry when the last page is full. A search reads
// each stored key from key memory and compares it. Status gives one row per
// cycle while results are taken. The back end serves one item at a time.
// Reset opens one empty page and sets the page capacity to 4096; the key
// memory keeps no reset value. A stalled receiver holds the result register,
// and the back end takes no new item until that result is taken; the front
// queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_page_record_store #(
	parameter int MAX_PAGES     = 16,
	parameter int MAX_SLOTS     = 64,
	parameter int SLOT_OVERHEAD = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [15:0]        record_size,
	input  logic signed [31:0] key,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [3:0]         page_id,
	output logic [5:0]         slot_id,
	output logic [4:0]         page_count,
	output logic [6:0]         record_count,
	output logic               last
);

	logic [15:0] page_cap_q;
	logic        q_valid;
	logic        q_ready;
	logic        busy;
	ffps_pkg::cmd_item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_cap_q <= ffps_pkg::PAGE_CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			page_cap_q <= cfg_data;
		end
	end

	ffps_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .record_size(record_size), .key(key),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	ffps_back #(
		.MAX_PAGES(MAX_PAGES), .MAX_SLOTS(MAX_SLOTS), .SLOT_OVERHEAD(SLOT_OVERHEAD)
	) u_back (
		.clk(clk), .arst_n(arst_n), .page_cap(page_cap_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .page_id(page_id), .slot_id(slot_id),
		.page_count(page_count), .record_count(record_count), .last(last),
		.busy(busy)
	);

	`ASSERT_IMPL(a_cfg_when_quiet, clk, arst_n, cfg_valid, !busy)

endmodule
